FILE: hdl/gn2d_pkg.sv
// Shared types and constants of the 2D gradient noise evaluation core.
`default_nettype none

package gn2d_pkg;

   // Pipeline depth, from the accepting register to the result register.
   localparam int STAGES = 12;

   // Datapath widths.
   localparam int CADDR_W = 15;   // corner address before the table bound check
   localparam int PROD_W  = 34;   // gradient component times corner offset
   localparam int VAL_W   = 36;   // dot products and blended values, Q.30
   localparam int MUL_W   = 54;   // blend difference times weight
   localparam int NUM_W   = 50;   // smoothstep numerator
   localparam int WGT_W   = 17;   // smoothstep weight, Q0.16, 0..65536
   localparam int RND_W   = 37;   // final rounding sum

   // Transaction kinds.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_EVAL  = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_CELL_SHIFT   = 2'd0;
   localparam logic [1:0] CSR_OCTAVE_SHIFT = 2'd1;
   localparam logic [1:0] CSR_GRID_WIDTH   = 2'd2;

   // Register reset values.
   localparam logic [2:0] CELL_SHIFT_RST   = 3'd3;
   localparam logic [2:0] OCTAVE_SHIFT_RST = 3'd0;
   localparam logic [5:0] GRID_WIDTH_RST   = 6'd33;

   // Arithmetic constants.
   localparam logic [17:0]        SMOOTH_K    = 18'd196608;     // three times one in Q0.16
   localparam logic [NUM_W-1:0]   SMOOTH_HALF = 50'd2147483648; // half of the final shift
   localparam logic signed [17:0] ONE_Q16     = 18'sd65536;
   localparam logic signed [RND_W-1:0] SAT_MAX = 37'sd32767;
   localparam logic signed [RND_W-1:0] SAT_MIN = -37'sd32768;

   // One gradient table entry, both components in Q1.14.
   typedef struct packed {
      logic signed [15:0] gx;
      logic signed [15:0] gy;
   } grad_word_type;

   // Stage 1: captured transaction, cell and in-cell offsets.
   typedef struct packed {
      logic          is_write;
      logic          wr_ok;
      logic [10:0]   grad_index;
      grad_word_type grad;
      logic [15:0]   tx;
      logic [15:0]   ty;
      logic [7:0]    cx;
      logic [7:0]    cy;
   } s1_type;

   // Stage 2: corner addresses and squared offsets.
   typedef struct packed {
      logic                    is_write;
      logic                    wr_ok;
      logic [10:0]             grad_index;
      grad_word_type           grad;
      logic [15:0]             tx;
      logic [15:0]             ty;
      logic [3:0][CADDR_W-1:0] addr;
      logic [3:0]              ok;
      logic [31:0]             t2x;
      logic [31:0]             t2y;
   } s2_type;

   // Stage 3: table read under way, smoothstep numerators.
   typedef struct packed {
      logic [3:0]       ok;
      logic [15:0]      tx;
      logic [15:0]      ty;
      logic [NUM_W-1:0] numx;
      logic [NUM_W-1:0] numy;
   } s3_type;

   // Stage 4: the eight gradient products and the weights.
   typedef struct packed {
      logic [3:0][1:0][PROD_W-1:0] prod;
      logic [WGT_W-1:0]            sx;
      logic [WGT_W-1:0]            sy;
   } s4_type;

   // Stage 5: the four corner dot products.
   typedef struct packed {
      logic [3:0][VAL_W-1:0] dot;
      logic [WGT_W-1:0]      sx;
      logic [WGT_W-1:0]      sy;
   } s5_type;

   // Stage 6: bases and differences of the two x blends.
   typedef struct packed {
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] c;
      logic signed [VAL_W-1:0] dab;
      logic signed [VAL_W-1:0] dcd;
      logic [WGT_W-1:0]        sx;
      logic [WGT_W-1:0]        sy;
   } s6_type;

   // Stage 7: weighted differences of the x blends.
   typedef struct packed {
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] c;
      logic signed [MUL_W-1:0] pab;
      logic signed [MUL_W-1:0] pcd;
      logic [WGT_W-1:0]        sy;
   } s7_type;

   // Stage 8: top and bottom rows blended along x.
   typedef struct packed {
      logic signed [VAL_W-1:0] top;
      logic signed [VAL_W-1:0] bot;
      logic [WGT_W-1:0]        sy;
   } s8_type;

   // Stage 9: difference of the y blend.
   typedef struct packed {
      logic signed [VAL_W-1:0] top;
      logic signed [VAL_W-1:0] dtb;
      logic [WGT_W-1:0]        sy;
   } s9_type;

   // Stage 10: weighted difference of the y blend.
   typedef struct packed {
      logic signed [VAL_W-1:0] top;
      logic signed [MUL_W-1:0] ptb;
   } s10_type;

   // Stage 11: blended value in Q.30.
   typedef struct packed {
      logic signed [VAL_W-1:0] v;
   } s11_type;

endpackage

`default_nettype wire

FILE: hdl/gn2d_grad_ram.sv
// Gradient table memory with one write port and two registered read ports.
`default_nettype none

module gn2d_grad_ram
   import gn2d_pkg::*;
#(
   parameter int DEPTH  = 1089,
   parameter int ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire grad_word_type     wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output grad_word_type          rd_data_a,
   output grad_word_type          rd_data_b
);

   grad_word_type mem_ff [DEPTH];
   grad_word_type rd_data_a_ff;
   grad_word_type rd_data_b_ff;

   // Write port; the read data registers hold while the reader is stalled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

FILE: hdl/gradient_noise_2d_eval_core.sv
// Top level of the 2D gradient noise evaluation core.
//
// The core evaluates one octave of 2D gradient noise, one pixel per transaction, and takes
// one transaction in every cycle while a stage is empty or rsp_ready is high. A write
// transaction stores a Q1.14 gradient into the table when its index lies inside the table,
// and gives no result. An evaluate transaction gives one Q2.14 noise value; rsp_valid rises
// when it reaches the result register. A pixel outside the map gives no result.
// The rate is set by a twelve-stage pipeline with a stall-aware valid bit in every stage,
// and by the gradient table, which is held in two identical copies of a RAM with two read
// ports each, so that all four cell corners are read in the same cycle. The table needs no
// clearing pass: every entry must be written before an evaluation reads it. Configuration
// writes are taken at once and must only be made while no transaction is in flight.
`default_nettype none

module gradient_noise_2d_eval_core
   import gn2d_pkg::*;
#(
   parameter int MAP_SIDE  = 256,
   parameter int GRID_SIDE = 33
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Input transactions
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_action,
   input  wire logic [10:0]        req_grad_index,
   input  wire logic signed [15:0] req_grad_x,
   input  wire logic signed [15:0] req_grad_y,
   input  wire logic [7:0]         req_pixel_x,
   input  wire logic [7:0]         req_pixel_y,
   // Result transactions
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_noise_value,
   // Configuration writes
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [5:0]         csr_data
);

   localparam int TABLE_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // Configuration registers
   logic [2:0] cell_shift_ff;
   logic [2:0] octave_shift_ff;
   logic [5:0] grid_width_ff;

   // Pipeline control
   logic [STAGES:1] vld_ff;
   logic [STAGES:1] vld_in;
   logic [STAGES:1] en;
   logic            in_map;

   // Stage registers
   s1_type  s1_ff,  s1_in;
   s2_type  s2_ff,  s2_in;
   s3_type  s3_ff,  s3_in;
   s4_type  s4_ff,  s4_in;
   s5_type  s5_ff,  s5_in;
   s6_type  s6_ff,  s6_in;
   s7_type  s7_ff,  s7_in;
   s8_type  s8_ff,  s8_in;
   s9_type  s9_ff,  s9_in;
   s10_type s10_ff, s10_in;
   s11_type s11_ff, s11_in;
   logic signed [15:0] noise_ff, noise_in;

   // Stage 1 working signals
   logic [7:0]  lo_x, lo_y;
   logic [3:0]  frac_shift;
   logic [23:0] tx_wide, ty_wide;

   // Stage 2 working signals
   logic [CADDR_W-1:0] row_base;

   // Table access
   logic [31:0]   corner_ext [4];
   logic [31:0]   wr_ext;
   logic          wr_en;
   grad_word_type rd_word [4];

   // Stage 3 and 4 working signals
   logic [17:0]        fac_x, fac_y;
   logic [NUM_W-1:0]   wsum_x, wsum_y;
   grad_word_type      grad_m [4];
   logic signed [17:0] dx_near, dx_far, dy_near, dy_far;

   // Blend and output working signals
   logic signed [17:0]      sx_s, sy_s;
   logic [4:0]              round_k;
   logic signed [RND_W-1:0] round_sum, shifted;

   // Configuration port: always ready, unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_shift_ff   <= CELL_SHIFT_RST;
         octave_shift_ff <= OCTAVE_SHIFT_RST;
         grid_width_ff   <= GRID_WIDTH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CELL_SHIFT:   cell_shift_ff   <= csr_data[2:0];
            CSR_OCTAVE_SHIFT: octave_shift_ff <= csr_data[2:0];
            CSR_GRID_WIDTH:   grid_width_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // A stage loads when it is empty or when some later stage, or the output, makes room.
   always_comb begin
      for (int i = 1; i <= STAGES; i++) begin
         en[i] = rsp_ready;
         for (int j = i; j <= STAGES; j++) begin
            en[i] = en[i] | ~vld_ff[j];
         end
      end
      // Writes end at the table; pixels outside the map are dropped on entry.
      vld_in[1] = req_valid && (s1_in.is_write || in_map);
      vld_in[2] = vld_ff[1];
      vld_in[3] = vld_ff[2] && !s2_ff.is_write;
      for (int i = 4; i <= STAGES; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign req_ready       = en[1];
   assign rsp_valid       = vld_ff[STAGES];
   assign rsp_noise_value = noise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Stage 1: cell index and in-cell offset t = (4m + 1) << (14 - shift).
   always_comb begin
      lo_x       = req_pixel_x & ~(8'hFF << cell_shift_ff);
      lo_y       = req_pixel_y & ~(8'hFF << cell_shift_ff);
      frac_shift = 4'd14 - {1'b0, cell_shift_ff};
      tx_wide    = 24'({lo_x, 2'b01}) << frac_shift;
      ty_wide    = 24'({lo_y, 2'b01}) << frac_shift;
      in_map     = (32'(req_pixel_x) < MAP_SIDE) && (32'(req_pixel_y) < MAP_SIDE);

      s1_in.is_write   = (req_action == ACT_WRITE);
      s1_in.wr_ok      = (32'(req_grad_index) < TABLE_DEPTH);
      s1_in.grad_index = req_grad_index;
      s1_in.grad.gx    = req_grad_x;
      s1_in.grad.gy    = req_grad_y;
      s1_in.tx         = tx_wide[15:0];
      s1_in.ty         = ty_wide[15:0];
      s1_in.cx         = req_pixel_x >> cell_shift_ff;
      s1_in.cy         = req_pixel_y >> cell_shift_ff;
   end

   // Stage 2: the four corner addresses with their bound checks, and t squared.
   always_comb begin
      row_base         = CADDR_W'(s1_ff.cy) * CADDR_W'(grid_width_ff);
      s2_in.is_write   = s1_ff.is_write;
      s2_in.wr_ok      = s1_ff.wr_ok;
      s2_in.grad_index = s1_ff.grad_index;
      s2_in.grad       = s1_ff.grad;
      s2_in.tx         = s1_ff.tx;
      s2_in.ty         = s1_ff.ty;
      s2_in.addr[0]    = row_base + CADDR_W'(s1_ff.cx);
      s2_in.addr[1]    = s2_in.addr[0] + CADDR_W'(1);
      s2_in.addr[2]    = s2_in.addr[0] + CADDR_W'(grid_width_ff);
      s2_in.addr[3]    = s2_in.addr[2] + CADDR_W'(1);
      for (int i = 0; i < 4; i++) begin
         s2_in.ok[i] = (32'(s2_in.addr[i]) < TABLE_DEPTH);
      end
      s2_in.t2x = 32'(s1_ff.tx) * 32'(s1_ff.tx);
      s2_in.t2y = 32'(s1_ff.ty) * 32'(s1_ff.ty);
   end

   // Table access: writes and reads both happen as a transaction leaves stage 2,
   // so every evaluation sees exactly the writes accepted before it.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         corner_ext[i] = 32'(s2_ff.addr[i]);
      end
      wr_ext = 32'(s2_ff.grad_index);
      wr_en  = en[3] && vld_ff[2] && s2_ff.is_write && s2_ff.wr_ok;
   end

   gn2d_grad_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram_near (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_ext[ADDR_W-1:0]),
      .wr_data   (s2_ff.grad),
      .rd_en     (en[3]),
      .rd_addr_a (corner_ext[0][ADDR_W-1:0]),
      .rd_addr_b (corner_ext[1][ADDR_W-1:0]),
      .rd_data_a (rd_word[0]),
      .rd_data_b (rd_word[1])
   );

   gn2d_grad_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram_far (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_ext[ADDR_W-1:0]),
      .wr_data   (s2_ff.grad),
      .rd_en     (en[3]),
      .rd_addr_a (corner_ext[2][ADDR_W-1:0]),
      .rd_addr_b (corner_ext[3][ADDR_W-1:0]),
      .rd_data_a (rd_word[2]),
      .rd_data_b (rd_word[3])
   );

   // Stage 3: smoothstep numerator t^2 * (3 - 2t), all in fixed point.
   always_comb begin
      fac_x      = SMOOTH_K - {1'b0, s2_ff.tx, 1'b0};
      fac_y      = SMOOTH_K - {1'b0, s2_ff.ty, 1'b0};
      s3_in.ok   = s2_ff.ok;
      s3_in.tx   = s2_ff.tx;
      s3_in.ty   = s2_ff.ty;
      s3_in.numx = NUM_W'(s2_ff.t2x) * NUM_W'(fac_x);
      s3_in.numy = NUM_W'(s2_ff.t2y) * NUM_W'(fac_y);
   end

   // Stage 4: gradient products; a corner outside the table counts as a zero gradient.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         grad_m[i] = s3_ff.ok[i] ? rd_word[i] : '0;
      end
      dx_near = $signed({2'b00, s3_ff.tx});
      dy_near = $signed({2'b00, s3_ff.ty});
      dx_far  = dx_near - ONE_Q16;
      dy_far  = dy_near - ONE_Q16;

      s4_in.prod[0][0] = PROD_W'(grad_m[0].gx) * PROD_W'(dx_near);
      s4_in.prod[0][1] = PROD_W'(grad_m[0].gy) * PROD_W'(dy_near);
      s4_in.prod[1][0] = PROD_W'(grad_m[1].gx) * PROD_W'(dx_far);
      s4_in.prod[1][1] = PROD_W'(grad_m[1].gy) * PROD_W'(dy_near);
      s4_in.prod[2][0] = PROD_W'(grad_m[2].gx) * PROD_W'(dx_near);
      s4_in.prod[2][1] = PROD_W'(grad_m[2].gy) * PROD_W'(dy_far);
      s4_in.prod[3][0] = PROD_W'(grad_m[3].gx) * PROD_W'(dx_far);
      s4_in.prod[3][1] = PROD_W'(grad_m[3].gy) * PROD_W'(dy_far);

      // Weights rounded half up from the numerator.
      wsum_x   = s3_ff.numx + SMOOTH_HALF;
      wsum_y   = s3_ff.numy + SMOOTH_HALF;
      s4_in.sx = wsum_x[48:32];
      s4_in.sy = wsum_y[48:32];
   end

   // Stage 5: corner dot products.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s5_in.dot[i] = VAL_W'($signed(s4_ff.prod[i][0])) + VAL_W'($signed(s4_ff.prod[i][1]));
      end
      s5_in.sx = s4_ff.sx;
      s5_in.sy = s4_ff.sy;
   end

   // Stage 6: differences for the two blends along x.
   always_comb begin
      s6_in.a   = $signed(s5_ff.dot[0]);
      s6_in.c   = $signed(s5_ff.dot[2]);
      s6_in.dab = $signed(s5_ff.dot[1]) - $signed(s5_ff.dot[0]);
      s6_in.dcd = $signed(s5_ff.dot[3]) - $signed(s5_ff.dot[2]);
      s6_in.sx  = s5_ff.sx;
      s6_in.sy  = s5_ff.sy;
   end

   // Stage 7: weight the x differences.
   always_comb begin
      sx_s      = $signed({1'b0, s6_ff.sx});
      s7_in.a   = s6_ff.a;
      s7_in.c   = s6_ff.c;
      s7_in.pab = MUL_W'(s6_ff.dab) * MUL_W'(sx_s);
      s7_in.pcd = MUL_W'(s6_ff.dcd) * MUL_W'(sx_s);
      s7_in.sy  = s6_ff.sy;
   end

   // Stage 8: finish the x blends; the arithmetic shift floors.
   always_comb begin
      s8_in.top = s7_ff.a + VAL_W'(s7_ff.pab >>> 16);
      s8_in.bot = s7_ff.c + VAL_W'(s7_ff.pcd >>> 16);
      s8_in.sy  = s7_ff.sy;
   end

   // Stage 9: difference for the blend along y.
   always_comb begin
      s9_in.top = s8_ff.top;
      s9_in.dtb = s8_ff.bot - s8_ff.top;
      s9_in.sy  = s8_ff.sy;
   end

   // Stage 10: weight the y difference.
   always_comb begin
      sy_s       = $signed({1'b0, s9_ff.sy});
      s10_in.top = s9_ff.top;
      s10_in.ptb = MUL_W'(s9_ff.dtb) * MUL_W'(sy_s);
   end

   // Stage 11: finish the y blend.
   always_comb begin
      s11_in.v = s10_ff.top + VAL_W'(s10_ff.ptb >>> 16);
   end

   // Stage 12: round to Q2.14 with the octave shift, then saturate.
   always_comb begin
      round_k   = 5'd16 + 5'(octave_shift_ff);
      round_sum = RND_W'(s11_ff.v) + (RND_W'(1) <<< (round_k - 5'd1));
      shifted   = round_sum >>> round_k;
      if (shifted > SAT_MAX) begin
         noise_in = 16'sh7FFF;
      end else if (shifted < SAT_MIN) begin
         noise_in = 16'sh8000;
      end else begin
         noise_in = shifted[15:0];
      end
   end

   // Stage data registers; each loads together with its valid bit.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_ff <= s1_in;
      end
      if (en[2]) begin
         s2_ff <= s2_in;
      end
      if (en[3]) begin
         s3_ff <= s3_in;
      end
      if (en[4]) begin
         s4_ff <= s4_in;
      end
      if (en[5]) begin
         s5_ff <= s5_in;
      end
      if (en[6]) begin
         s6_ff <= s6_in;
      end
      if (en[7]) begin
         s7_ff <= s7_in;
      end
      if (en[8]) begin
         s8_ff <= s8_in;
      end
      if (en[9]) begin
         s9_ff <= s9_in;
      end
      if (en[10]) begin
         s10_ff <= s10_in;
      end
      if (en[11]) begin
         s11_ff <= s11_in;
      end
      if (en[12]) begin
         noise_ff <= noise_in;
      end
   end

   // An evaluation inside the map always enters the pipeline.
   a_eval_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_EVAL && in_map |=> vld_ff[1])
      else $error("accepted evaluation did not enter the pipeline");

   // A write transaction never travels past the table.
   a_write_ends: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && s2_ff.is_write && en[3] |=> !vld_ff[3])
      else $error("write transaction reached the arithmetic stages");

   // Stage 6, when it cannot move, keeps its transaction.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] && !en[7] |=> vld_ff[6])
      else $error("stalled transaction lost in the middle of the pipeline");

   // A waiting result does not block the input while there is a bubble ahead of it.
   a_bubble_accepts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !vld_ff[STAGES-1] |-> req_ready)
      else $error("input blocked although the pipeline has room");

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench for the 2D gradient noise core: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module tb
   import gn2d_pkg::*;
();

   localparam int MAP_SIDE     = 256;
   localparam int GRID_SIDE    = 33;
   localparam int TABLE_DEPTH  = GRID_SIDE * GRID_SIDE;
   localparam int LIMIT_CYCLES = 500000;
   localparam int PHASE_ITEMS  = 95;
   localparam int REPORT_MAX   = 10;
   // The fourth register index has no register behind it.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic               action;
      logic [10:0]        grad_index;
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
      logic [7:0]         pixel_x;
      logic [7:0]         pixel_y;
   } noise_txn_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_action;
   logic [10:0]        req_grad_index;
   logic signed [15:0] req_grad_x;
   logic signed [15:0] req_grad_y;
   logic [7:0]         req_pixel_x;
   logic [7:0]         req_pixel_y;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_noise_value;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [5:0]         csr_data;

   // Predictor state: gradient store, which entries hold data, and the register copies.
   logic signed [15:0] grad_x_mem [TABLE_DEPTH];
   logic signed [15:0] grad_y_mem [TABLE_DEPTH];
   bit                 grad_written [TABLE_DEPTH];
   int                 cur_cell_shift;
   int                 cur_octave_shift;
   int                 cur_grid_width;

   logic signed [15:0] pending_noise [$];
   logic signed [15:0] expected_noise;
   bit                 calm;
   int                 stall_left;
   int                 cycle_count;
   int                 fail_count;
   int                 results_checked;
   int                 eval_count;
   int                 write_count;
   int                 dropped_count;
   int                 config_count;

   gradient_noise_2d_eval_core #(
      .MAP_SIDE (MAP_SIDE),
      .GRID_SIDE(GRID_SIDE)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_grad_index (req_grad_index),
      .req_grad_x     (req_grad_x),
      .req_grad_y     (req_grad_y),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_noise_value(rsp_noise_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a correct run ends long before this.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
   end

   // Gap lengths: mostly none or short, now and then long, none at all in a calm stretch.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic signed [15:0] rand_grad();
      case ($urandom_range(0, 11))
         0:       return 16'sh7FFF;
         1:       return -16'sh8000;
         2:       return 16'sd16384;
         3:       return -16'sd16384;
         4:       return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Table address of one cell corner: bit 0 of the corner steps in x, bit 1 steps one row.
   function automatic int corner_addr(input logic [7:0] px, input logic [7:0] py,
                                      input int corner);
      int base;
      base = (int'(px) >> cur_cell_shift) + (int'(py) >> cur_cell_shift) * cur_grid_width;
      return base + (corner & 1) + (corner >> 1) * cur_grid_width;
   endfunction

   function automatic longint corner_dot(input int addr, input longint dx, input longint dy);
      if (addr >= TABLE_DEPTH) return 0;
      return longint'(grad_x_mem[addr]) * dx + longint'(grad_y_mem[addr]) * dy;
   endfunction

   // Smoothstep weight 3t^2 - 2t^3 in Q0.16, rounded half up.
   function automatic longint smooth_weight(input longint t);
      longint t2;
      longint t3;
      t2 = t * t;
      t3 = t2 * t;
      return (3 * t2 * 65536 - 2 * t3 + (longint'(1) << 31)) >>> 32;
   endfunction

   function automatic longint blend_q30(input longint a, input longint b, input longint s);
      return a + (((b - a) * s) >>> 16);
   endfunction

   // Noise at one pixel under the current registers and gradient store.
   function automatic logic signed [15:0] predict_noise(input logic [7:0] px,
                                                        input logic [7:0] py);
      longint mask;
      longint tx;
      longint ty;
      longint top;
      longint bot;
      longint v;
      int     k;
      mask = (longint'(1) << cur_cell_shift) - 1;
      tx   = (((longint'(px) & mask) << 2) + 1) << (14 - cur_cell_shift);
      ty   = (((longint'(py) & mask) << 2) + 1) << (14 - cur_cell_shift);
      top  = blend_q30(corner_dot(corner_addr(px, py, 0), tx, ty),
                       corner_dot(corner_addr(px, py, 1), tx - 65536, ty),
                       smooth_weight(tx));
      bot  = blend_q30(corner_dot(corner_addr(px, py, 2), tx, ty - 65536),
                       corner_dot(corner_addr(px, py, 3), tx - 65536, ty - 65536),
                       smooth_weight(tx));
      v    = blend_q30(top, bot, smooth_weight(ty));
      k    = 16 + cur_octave_shift;
      v    = (v + (longint'(1) << (k - 1))) >>> k;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // Apply an accepted transaction to the predictor.
   function automatic void record_accept(input noise_txn_type txn);
      if (txn.action == ACT_WRITE) begin
         if (txn.grad_index < TABLE_DEPTH) begin
            grad_x_mem[txn.grad_index]   = txn.grad_x;
            grad_y_mem[txn.grad_index]   = txn.grad_y;
            grad_written[txn.grad_index] = 1'b1;
            write_count++;
         end else begin
            dropped_count++;
         end
      end else begin
         pending_noise.push_back(predict_noise(txn.pixel_x, txn.pixel_y));
         eval_count++;
      end
   endfunction

   // Present one transaction after a random gap and hold it until it is taken.
   task automatic send_item(input noise_txn_type txn);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= txn.action;
      req_grad_index <= txn.grad_index;
      req_grad_x     <= txn.grad_x;
      req_grad_y     <= txn.grad_y;
      req_pixel_x    <= txn.pixel_x;
      req_pixel_y    <= txn.pixel_y;
      do @(posedge clock); while (!req_ready);
      record_accept(txn);
   endtask

   task automatic store_gradient(input int idx, input logic signed [15:0] gx,
                                 input logic signed [15:0] gy);
      noise_txn_type txn;
      txn.action     = ACT_WRITE;
      txn.grad_index = 11'(idx);
      txn.grad_x     = gx;
      txn.grad_y     = gy;
      txn.pixel_x    = 8'($urandom);
      txn.pixel_y    = 8'($urandom);
      send_item(txn);
   endtask

   // Evaluate a pixel, first loading any corner of its cell that has never been written.
   task automatic evaluate_at(input logic [7:0] px, input logic [7:0] py);
      noise_txn_type txn;
      int            addr;
      for (int corner = 0; corner < 4; corner++) begin
         addr = corner_addr(px, py, corner);
         if (addr < TABLE_DEPTH && !grad_written[addr])
            store_gradient(addr, rand_grad(), rand_grad());
      end
      txn.action     = ACT_EVAL;
      txn.grad_index = 11'($urandom);
      txn.grad_x     = 16'($urandom);
      txn.grad_y     = 16'($urandom);
      txn.pixel_x    = px;
      txn.pixel_y    = py;
      send_item(txn);
   endtask

   // Stop sending, let every result arrive and the pipeline empty of writes.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_noise.size() != 0) @(posedge clock);
      repeat (STAGES + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [5:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CELL_SHIFT:   cur_cell_shift   = data[2:0];
         CSR_OCTAVE_SHIFT: cur_octave_shift = data[2:0];
         CSR_GRID_WIDTH:   cur_grid_width   = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // New register setting; the unused upper data bits carry random values.
   task automatic set_config(input int cs, input int oct, input int gw);
      wait_idle();
      write_csr(CSR_CELL_SHIFT, {3'($urandom), 3'(cs)});
      write_csr(CSR_OCTAVE_SHIFT, {3'($urandom), 3'(oct)});
      write_csr(CSR_GRID_WIDTH, 6'(gw));
      config_count++;
   endtask

   // Reset values of the registers, including the last corner of the store.
   task automatic test_default_registers();
      calm = 1'b1;
      evaluate_at(8'd0, 8'd0);
      evaluate_at(8'd7, 8'd7);
      calm = 1'b0;
      evaluate_at(8'd255, 8'd255);
   endtask

   // Full-scale gradients drive the result close to its limits in both directions.
   task automatic test_gradient_extremes();
      store_gradient(0, 16'sh7FFF, 16'sh7FFF);
      store_gradient(1, -16'sh8000, 16'sh7FFF);
      store_gradient(GRID_SIDE, 16'sh7FFF, -16'sh8000);
      store_gradient(GRID_SIDE + 1, -16'sh8000, -16'sh8000);
      evaluate_at(8'd4, 8'd4);
      evaluate_at(8'd3, 8'd4);
      store_gradient(0, -16'sh8000, -16'sh8000);
      store_gradient(1, 16'sh7FFF, -16'sh8000);
      store_gradient(GRID_SIDE, -16'sh8000, 16'sh7FFF);
      store_gradient(GRID_SIDE + 1, 16'sh7FFF, 16'sh7FFF);
      evaluate_at(8'd4, 8'd4);
   endtask

   // Writes beyond the store are dropped; the last entry is still reachable.
   task automatic test_index_bounds();
      store_gradient(TABLE_DEPTH, 16'sh7FFF, -16'sh8000);
      store_gradient(2047, -16'sh8000, 16'sh7FFF);
      store_gradient(TABLE_DEPTH - 1, 16'sd16384, -16'sd16384);
      evaluate_at(8'd255, 8'd255);
   endtask

   // Register extremes: one-pixel and 128-pixel cells, zero and full grid widths,
   // the largest octave shift, and a write to the unused index.
   task automatic test_register_extremes();
      set_config(7, 7, 0);
      write_csr(CSR_UNUSED, 6'($urandom));
      evaluate_at(8'd255, 8'd255);
      evaluate_at(8'd0, 8'd127);
      set_config(0, 0, 63);
      evaluate_at(8'd255, 8'd255);
      evaluate_at(8'd1, 8'd0);
      set_config(1, 3, 1);
      evaluate_at(8'd255, 8'd3);
      set_config(6, 5, 2);
      evaluate_at(8'd255, 8'd64);
   endtask

   // Random phases: mostly evaluations with their corners loaded, plus overwrites
   // and dropped writes, each phase after the first under a random register setting.
   task automatic test_random_traffic();
      int phase_start;
      int r;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) set_config(3, 0, 33);
         else set_config($urandom_range(0, 7), $urandom_range(0, 7),
                         ($urandom_range(0, 1) != 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(2, 33));
         calm        = (phase == 2);
         phase_start = eval_count + write_count;
         while (eval_count + write_count - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 49) == 0) calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 70) evaluate_at(rand_coord(), rand_coord());
            else if (r < 92)
               store_gradient($urandom_range(0, TABLE_DEPTH - 1), rand_grad(), rand_grad());
            else store_gradient($urandom_range(TABLE_DEPTH, 2047), rand_grad(), rand_grad());
         end
      end
      calm = 1'b0;
   endtask

   // Result side back-pressure.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Compare each result transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_noise.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("Cycle %0d: unexpected noise result %0d", cycle_count, rsp_noise_value);
         end else begin
            expected_noise = pending_noise.pop_front();
            results_checked++;
            if (rsp_noise_value !== expected_noise) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("Cycle %0d: noise mismatch, expected %0d, got %0d",
                           cycle_count, expected_noise, rsp_noise_value);
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_WRITE;
      req_grad_index   = '0;
      req_grad_x       = '0;
      req_grad_y       = '0;
      req_pixel_x      = '0;
      req_pixel_y      = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_CELL_SHIFT;
      csr_data         = '0;
      calm             = 1'b0;
      stall_left       = 0;
      fail_count       = 0;
      results_checked  = 0;
      eval_count       = 0;
      write_count      = 0;
      dropped_count    = 0;
      config_count     = 0;
      cur_cell_shift   = CELL_SHIFT_RST;
      cur_octave_shift = OCTAVE_SHIFT_RST;
      cur_grid_width   = GRID_WIDTH_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_registers();
      test_gradient_extremes();
      test_index_bounds();
      test_register_extremes();
      test_random_traffic();
      wait_idle();

      $display("Run: %0d evaluations, %0d gradient writes, %0d out-of-range writes dropped,",
               eval_count, write_count, dropped_count);
      $display("     %0d noise results checked over %0d register settings, %0d failures.",
               results_checked, config_count, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
